/* rtl/irq_pkg.sv */
// Shared types and constants for the int8 requantiser.
// No dependencies; used by the pipeline, the top level and the checker.
`timescale 1ns / 1ps

package irq_pkg;

    localparam int ACC_W      = 32;
    localparam int OUT_W      = 8;
    localparam int SCALE_W    = 30;
    localparam int MANT_W     = 23;
    localparam int EXP_W      = SCALE_W - MANT_W;
    localparam int MULT_W     = MANT_W + 1 + 7;    // hidden one, then << 7
    localparam int POST_W     = 6;                 // post-shift capped at 63
    localparam int MID_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [EXP_W-1:0]  SHIFT_BASE = EXP_W'(126);
    localparam logic [POST_W-1:0] POST_MAX   = POST_W'(63);

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ZP      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = CFG_IDX_W'(3);

    localparam logic [SCALE_W-1:0]     SCALE_RESET = SCALE_W'(32'h3F00_0000);
    localparam logic signed [OUT_W-1:0] ZP_RESET   = OUT_W'(0);
    localparam logic signed [OUT_W-1:0] MIN_RESET  = OUT_W'(8'h80);
    localparam logic signed [OUT_W-1:0] MAX_RESET  = OUT_W'(8'h7F);

    // settings decoded from the registers, handed to the pipeline
    typedef struct packed {
        logic [MULT_W-1:0]       mult;
        logic [POST_W-1:0]       post;
        logic                    dbl_in;
        logic signed [OUT_W-1:0] zp;
        logic signed [OUT_W-1:0] out_min;
        logic signed [OUT_W-1:0] out_max;
    } irq_cfg_t;

endpackage

/* rtl/int8_requantize_rndnu.sv */
// An accepted input beat passes a_reg, p_reg, m_reg and q_reg to reach m_.
// Throughput: one beat per cycle; the four pipeline stages advance together
// and hold as a whole only while a result sits unaccepted on m_.
// The 32x31 multiply in stage 2 is the widest step.
// Reset (aresetn low, synchronous): pipeline emptied, registers to their
// defaults (scale 0.5, zero point 0, clamp -128..127). Config always ready.
`timescale 1ns / 1ps

module int8_requantize_rndnu (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [irq_pkg::ACC_W-1:0]     s_accumulator,
    input  logic                                 s_last_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [irq_pkg::OUT_W-1:0]     m_quantized,
    output logic                                 m_last_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [irq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [irq_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SCALE_W = irq_pkg::SCALE_W;
    localparam int MANT_W  = irq_pkg::MANT_W;
    localparam int EXP_W   = irq_pkg::EXP_W;
    localparam int OUT_W   = irq_pkg::OUT_W;
    localparam int POST_W  = irq_pkg::POST_W;

    logic [SCALE_W-1:0]       scale_reg;
    logic signed [OUT_W-1:0]  zp_reg;
    logic signed [OUT_W-1:0]  min_reg;
    logic signed [OUT_W-1:0]  max_reg;

    logic [EXP_W-1:0]         expo;
    logic [EXP_W-1:0]         diff;
    irq_pkg::irq_cfg_t        cfg;
    logic                     en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= irq_pkg::SCALE_RESET;
            zp_reg    <= irq_pkg::ZP_RESET;
            min_reg   <= irq_pkg::MIN_RESET;
            max_reg   <= irq_pkg::MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                irq_pkg::CFG_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                irq_pkg::CFG_ZP:      zp_reg    <= cfg_data[OUT_W-1:0];
                irq_pkg::CFG_OUT_MIN: min_reg   <= cfg_data[OUT_W-1:0];
                irq_pkg::CFG_OUT_MAX: max_reg   <= cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // exponent 126 and 127 both mean a zero shift: pre-shift and post-shift of one
    always_comb begin
        expo           = scale_reg[SCALE_W-1:MANT_W];
        diff           = irq_pkg::SHIFT_BASE - expo;
        cfg.mult       = {1'b1, scale_reg[MANT_W-1:0], 7'b0};
        cfg.dbl_in     = (expo >= irq_pkg::SHIFT_BASE);
        if (expo >= irq_pkg::SHIFT_BASE) begin
            cfg.post = POST_W'(1);
        end else if (diff > EXP_W'(irq_pkg::POST_MAX)) begin
            cfg.post = irq_pkg::POST_MAX;
        end else begin
            cfg.post = diff[POST_W-1:0];
        end
        cfg.zp         = zp_reg;
        cfg.out_min    = min_reg;
        cfg.out_max    = max_reg;
    end

    // whole pipe moves unless the output beat is stuck
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    irq_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_acc    (s_accumulator),
        .in_last   (s_last_in),
        .cfg       (cfg),
        .out_valid (m_valid),
        .out_q     (m_quantized),
        .out_last  (m_last_out)
    );

endmodule

/* rtl/irq_pipe.sv */
// Four-stage requantisation datapath: pre-shift, multiply, rounding shift,
// zero point / saturation / clamp. Depends on irq_pkg.
`timescale 1ns / 1ps

module irq_pipe (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [irq_pkg::ACC_W-1:0]   in_acc,
    input  logic                               in_last,
    input  irq_pkg::irq_cfg_t                  cfg,
    output logic                               out_valid,
    output logic signed [irq_pkg::OUT_W-1:0]   out_q,
    output logic                               out_last
);

    localparam int ACC_W  = irq_pkg::ACC_W;
    localparam int OUT_W  = irq_pkg::OUT_W;
    localparam int MID_W  = irq_pkg::MID_W;
    localparam int POST_W = irq_pkg::POST_W;
    localparam int RND_W  = ACC_W + 1;
    localparam int PROD_W = 2 * ACC_W;
    localparam int SUM_W  = MID_W + 1;
    localparam int SH_W   = $clog2(ACC_W);

    logic [3:0] vld_reg;
    logic [3:0] last_reg;

    logic signed [ACC_W-1:0]  a_reg, a_next;
    logic signed [ACC_W-1:0]  p_reg, p_next;
    logic signed [MID_W-1:0]  m_reg, m_next;
    logic signed [OUT_W-1:0]  q_reg, q_next;

    logic signed [PROD_W-1:0] prod;
    logic signed [RND_W-1:0]  rsum, rval;
    logic signed [SUM_W-1:0]  zsum;
    logic signed [OUT_W-1:0]  s8;
    logic [SH_W-1:0]          sh;

    // stage 1: pre-shift wraps within 32 bits
    always_comb begin
        a_next = cfg.dbl_in ? {in_acc[ACC_W-2:0], 1'b0} : in_acc;
    end

    // stage 2: doubling high multiply; the multiplier is positive and below 2^31
    always_comb begin
        prod   = a_reg * $signed({1'b0, cfg.mult});
        p_next = prod[2*ACC_W-2:ACC_W-1];
    end

    // stage 3: round half up, arithmetic shift, saturate to 16 bits
    always_comb begin
        sh   = cfg.post[SH_W-1:0];
        rsum = {p_reg[ACC_W-1], p_reg} + (RND_W'(1) << (sh - SH_W'(1)));
        rval = rsum >>> sh;
        if (cfg.post >= POST_W'(ACC_W)) begin
            m_next = '0;    // shift beyond the word: always rounds to zero
        end else if (rval > RND_W'(32767)) begin
            m_next = MID_W'(16'h7FFF);
        end else if (rval < -RND_W'(32768)) begin
            m_next = MID_W'(16'h8000);
        end else begin
            m_next = rval[MID_W-1:0];
        end
    end

    // stage 4: zero point, 8-bit saturation, clamp (max first, then min)
    always_comb begin
        zsum = {m_reg[MID_W-1], m_reg} + SUM_W'(cfg.zp);
        if (zsum > SUM_W'(127)) begin
            s8 = OUT_W'(8'h7F);
        end else if (zsum < -SUM_W'(128)) begin
            s8 = OUT_W'(8'h80);
        end else begin
            s8 = zsum[OUT_W-1:0];
        end
        q_next = s8;
        if (q_next > cfg.out_max) begin
            q_next = cfg.out_max;
        end
        if (q_next < cfg.out_min) begin
            q_next = cfg.out_min;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[2:0], in_last};
            a_reg    <= a_next;
            p_reg    <= p_next;
            m_reg    <= m_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_q     = q_reg;
    assign out_last  = last_reg[3];

endmodule

/* rtl/irq_checker.sv */
// Port-level checks for int8_requantize_rndnu, attached by bind.
// Depends on irq_pkg for widths.
`timescale 1ns / 1ps

module irq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [irq_pkg::OUT_W-1:0]   m_quantized,
    input logic                               m_last_out
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quantized) && $stable(m_last_out))
        else $error("result beat changed while stalled");

    // input side never blocks while the output is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready with empty output");

    // with m_ready high while it moves down the pipeline, an accepted beat reaches m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result beat missing after pipeline latency");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind int8_requantize_rndnu irq_checker u_irq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_quantized (m_quantized),
    .m_last_out  (m_last_out)
);

/* tb/requant_checker.sv */
// Checker for int8_requantize_rndnu: tracks register writes, predicts each result beat
// from the accepted input beats and compares it with the m_ channel.
// Depends on irq_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module requant_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [irq_pkg::ACC_W-1:0]     s_accumulator,
    input  logic                                 s_last_in,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [irq_pkg::OUT_W-1:0]     m_quantized,
    input  logic                                 m_last_out,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [irq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [irq_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                   pending,
    output int                                   errors
);

    localparam int ACC_W   = irq_pkg::ACC_W;
    localparam int OUT_W   = irq_pkg::OUT_W;
    localparam int SCALE_W = irq_pkg::SCALE_W;
    localparam int MANT_W  = irq_pkg::MANT_W;
    localparam int EXP_W   = irq_pkg::EXP_W;

    typedef struct packed {
        logic signed [OUT_W-1:0] quantized;
        logic                    last;
    } quant_beat_t;

    logic [SCALE_W-1:0]      scale_cfg;
    logic signed [OUT_W-1:0] zp_cfg;
    logic signed [OUT_W-1:0] out_min;
    logic signed [OUT_W-1:0] out_max;

    quant_beat_t quant_due [$];
    int          outstanding = 0;
    int          fail_count  = 0;

    assign pending = outstanding;
    assign errors  = fail_count;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // scale -> multiplier/shift, doubling high multiply, round half up, saturate, clamp
    function automatic logic signed [OUT_W-1:0] requantise(
        input logic signed [ACC_W-1:0] acc,
        input logic [SCALE_W-1:0]      scale,
        input logic signed [OUT_W-1:0] zp,
        input logic signed [OUT_W-1:0] lo,
        input logic signed [OUT_W-1:0] hi
    );
        logic [EXP_W-1:0]        expo;
        logic signed [ACC_W-1:0] doubled;
        longint                  mult;
        longint                  a;
        longint                  p;
        longint                  v;
        int                      shift;
        int                      post;

        expo  = scale[SCALE_W-1:MANT_W];
        mult  = longint'({1'b1, scale[MANT_W-1:0]}) <<< 7;
        shift = 126 - int'(expo);
        if (shift < 0) shift = 0;
        post = (shift < 1) ? 1 : shift;
        if (post > 63) post = 63;

        // zero shift: pre-shift left by one, wrapping in 32 bits
        doubled = acc << 1;
        a = (shift == 0) ? longint'(doubled) : longint'(acc);

        p = (a * mult) >>> 31;
        v = (p + (longint'(1) << (post - 1))) >>> post;

        v = clip(v, -32768, 32767);
        v = clip(v + longint'(zp), -32768, 32767);
        v = clip(v, -128, 127);
        if (v > longint'(hi)) v = longint'(hi);
        if (v < longint'(lo)) v = longint'(lo);
        return v[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        quant_beat_t want;
        if (!aresetn) begin
            scale_cfg = irq_pkg::SCALE_RESET;
            zp_cfg    = irq_pkg::ZP_RESET;
            out_min   = irq_pkg::MIN_RESET;
            out_max   = irq_pkg::MAX_RESET;
            quant_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (quant_due.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d/%0b with nothing outstanding",
                                              m_quantized, m_last_out));
                end else begin
                    want = quant_due.pop_front();
                    if (m_quantized !== want.quantized)
                        report_mismatch($sformatf("quantized %0d, expected %0d",
                                                  m_quantized, want.quantized));
                    if (m_last_out !== want.last)
                        report_mismatch($sformatf("last_out %b, expected %b",
                                                  m_last_out, want.last));
                end
            end
            if (s_valid && s_ready)
                quant_due.push_back('{requantise(s_accumulator, scale_cfg, zp_cfg,
                                                 out_min, out_max), s_last_in});
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    irq_pkg::CFG_SCALE:   scale_cfg = cfg_data[SCALE_W-1:0];
                    irq_pkg::CFG_ZP:      zp_cfg    = cfg_data[OUT_W-1:0];
                    irq_pkg::CFG_OUT_MIN: out_min   = cfg_data[OUT_W-1:0];
                    irq_pkg::CFG_OUT_MAX: out_max   = cfg_data[OUT_W-1:0];
                    default: ;     // unmapped index: no effect
                endcase
            end
        end
        outstanding = quant_due.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the int8_requantize_rndnu testbench: clock, reset, register programming,
// input beats and result back-pressure; requant_checker does the prediction.
// Depends on irq_pkg, int8_requantize_rndnu and requant_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int ACC_W      = irq_pkg::ACC_W;
    localparam int OUT_W      = irq_pkg::OUT_W;
    localparam int SCALE_W    = irq_pkg::SCALE_W;
    localparam int MANT_W     = irq_pkg::MANT_W;
    localparam int EXP_W      = irq_pkg::EXP_W;
    localparam int CFG_IDX_W  = irq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = irq_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 20;
    localparam int PHASE_BEATS  = 85;
    localparam int SETTLE       = 8;

    localparam logic [SCALE_W-1:0] SCALE_EXP_MAX = 30'h3FFF_FFFF; // exponent 127, full mantissa
    localparam logic [SCALE_W-1:0] SCALE_TINY    = 30'h2F00_0000; // below 2^-32
    localparam logic [SCALE_W-1:0] SCALE_FLOOR   = 30'h2F80_0000; // exactly 2^-32
    localparam logic [SCALE_W-1:0] SCALE_TOP     = 30'h3F7F_FFFF; // just under one
    localparam logic [SCALE_W-1:0] SCALE_QUARTER = 30'h3E80_0000;
    localparam logic signed [OUT_W-1:0] Q_MIN = -8'sd128;
    localparam logic signed [OUT_W-1:0] Q_MAX = 8'sd127;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [ACC_W-1:0]     s_accumulator = '0;
    logic                        s_last_in     = 1'b0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic signed [OUT_W-1:0]     m_quantized;
    logic                        m_last_out;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index     = irq_pkg::CFG_SCALE;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;

    int pending;
    int errors;
    int cycle_count = 0;
    bit quiet       = 1'b0;

    logic signed [ACC_W-1:0] corner_acc [8] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF,
        32'sh8000_0000, 32'sd255, -32'sd257, 32'sh5555_5555
    };

    always #5 aclk = ~aclk;

    int8_requantize_rndnu dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accumulator (s_accumulator),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quantized   (m_quantized),
        .m_last_out    (m_last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    requant_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accumulator (s_accumulator),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quantized   (m_quantized),
        .m_last_out    (m_last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .errors        (errors)
    );

    // result back-pressure: stall with odds of about 19 in 100 unless in a quiet stretch
    always @(posedge aclk)
        m_ready <= quiet || ($urandom_range(99) >= 19);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge the beat is taken, valid left high
    task automatic send_beat(input logic signed [ACC_W-1:0] acc, input logic last);
        while (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_accumulator <= acc;
        s_last_in     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold the sender off until every outstanding result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // only called with the block idle; upper data bits carry junk
    task automatic program_regs(input logic [SCALE_W-1:0] scale,
                                input logic signed [OUT_W-1:0] zp,
                                input logic signed [OUT_W-1:0] lo,
                                input logic signed [OUT_W-1:0] hi,
                                input bit unmapped);
        logic [CFG_IDX_W-1:0]  idx  [5];
        logic [CFG_DATA_W-1:0] word [5];
        int                    n;
        int                    i;

        idx[0] = irq_pkg::CFG_SCALE;
        idx[1] = irq_pkg::CFG_ZP;
        idx[2] = irq_pkg::CFG_OUT_MIN;
        idx[3] = irq_pkg::CFG_OUT_MAX;
        idx[4] = CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1,
                                           int'(irq_pkg::CFG_OUT_MAX) + 1));
        for (i = 0; i < 5; i++) word[i] = $urandom();
        word[0][SCALE_W-1:0] = scale;
        word[1][OUT_W-1:0]   = zp;
        word[2][OUT_W-1:0]   = lo;
        word[3][OUT_W-1:0]   = hi;
        n = unmapped ? 5 : 4;
        for (i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= word[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings(input bit unmapped);
        logic [EXP_W-1:0]        expo;
        logic [SCALE_W-1:0]      scale;
        logic signed [OUT_W-1:0] zp;
        logic signed [OUT_W-1:0] a;
        logic signed [OUT_W-1:0] b;
        logic signed [OUT_W-1:0] lo;
        logic signed [OUT_W-1:0] hi;

        case ($urandom_range(9))
            0:       expo = EXP_W'(127);
            1:       expo = EXP_W'($urandom_range(94));
            default: expo = EXP_W'($urandom_range(126, 95));
        endcase
        scale = {expo, MANT_W'($urandom())};
        case ($urandom_range(19))
            0: scale = SCALE_FLOOR;
            1: scale = SCALE_TOP;
            2: scale = SCALE_EXP_MAX;
            default: ;
        endcase

        zp = OUT_W'($urandom());
        case ($urandom_range(9))
            0: zp = Q_MIN;
            1: zp = Q_MAX;
            default: ;
        endcase

        a = OUT_W'($urandom());
        b = OUT_W'($urandom());
        case ($urandom_range(9))
            0: begin
                lo = Q_MIN;
                hi = Q_MAX;
            end
            1: begin
                // crossed bounds
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            default: begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
        endcase
        program_regs(scale, zp, lo, hi, unmapped);
    endtask

    function automatic logic signed [ACC_W-1:0] pick_acc();
        logic signed [ACC_W-1:0] v;
        case ($urandom_range(9))
            0: v = $urandom();
            1: v = corner_acc[$urandom_range(7)];
            default: begin
                // spread magnitudes over every bit length so most scales see live outputs
                v = $urandom() >> $urandom_range(31);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    initial begin
        int i;
        int ph;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: scale 0.5 takes the pre-shift path
        for (i = 0; i < 8; i++) send_beat(corner_acc[i], i[0]);

        // scale of one or more
        drain();
        program_regs(SCALE_EXP_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b1);
        for (i = 1; i < 5; i++) send_beat(corner_acc[i], i[0]);

        // scale under 2^-32: everything rounds to zero
        drain();
        program_regs(SCALE_TINY, Q_MIN, Q_MIN, Q_MAX, 1'b0);
        for (i = 1; i < 5; i++) send_beat(corner_acc[i], 1'b1);

        drain();
        program_regs(SCALE_FLOOR, 8'sd0, Q_MIN, Q_MAX, 1'b0);
        send_beat(corner_acc[3], 1'b0);
        send_beat(corner_acc[4], 1'b1);
        send_beat(corner_acc[1], 1'b0);

        // lower bound above upper bound
        drain();
        program_regs(SCALE_QUARTER, 8'sd5, 8'sd100, -8'sd100, 1'b0);
        send_beat(corner_acc[0], 1'b0);
        send_beat(corner_acc[5], 1'b0);
        send_beat(corner_acc[6], 1'b1);

        drain();
        program_regs('0, -8'sd1, Q_MIN, Q_MAX, 1'b0);
        send_beat(corner_acc[3], 1'b0);
        send_beat(corner_acc[4], 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            quiet = (ph >= 8 && ph < 11);
            random_settings(ph % 5 == 0);
            for (i = 0; i < PHASE_BEATS; i++)
                send_beat(pick_acc(), $urandom_range(7) == 0);
        end
        quiet = 1'b0;

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
